// File: src/lzss_pkg.sv
// Shared types and constants for the LZSS bitstream decompressor.
// No dependencies; every other file in src/ refers to this package by scoped names.
package lzss_pkg;

   localparam int BYTE_BITS = 8;
   localparam int END_CODE  = 0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_packet;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       data_valid;
      logic       last_of_run;
      logic       stream_end;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic advance;
   } parse_ctrl_type;

   typedef struct packed {
      logic busy;
      logic last_bit;
      logic ev_literal;
      logic ev_end;
      logic ev_match;
   } parse_status_type;

   typedef struct packed {
      logic set_origin;
      logic lit_wr;
      logic copy_start;
      logic copy_take;
   } win_ctrl_type;

   typedef struct packed {
      logic clearing;
      logic copy_ready;
      logic copy_last;
   } win_status_type;

endpackage

// File: src/lzss_bitstream_decompressor.sv
// LZSS decompressor, 12-bit window index and 4-bit length by default. One compressed byte is
// taken per transaction and parsed one bit per clock, MSB first, while the parser is not held
// at a token whose result waits for the output. A literal or end token is written to the output
// register in the cycle its last bit is shifted; a match copies length+2 bytes from the window,
// each with one window read, then write-back and output, so each read follows the last write.
// The output register lets the next result wait for the receiver without losing work; a stalled
// receiver holds the parser at a literal or end token, or the copy engine at its next byte.
// After reset the window is swept to zero, one entry per cycle, and req_stall stays high until
// the sweep ends. The window keeps its contents across packets.
// Depends on lzss_pkg, lzss_bit_parser and lzss_window_copy.
module lzss_bitstream_decompressor #(
   parameter int INDEX_BITS   = 12,
   parameter int LENGTH_BITS  = 4,
   parameter int WINDOW_DEPTH = 4096,
   parameter int OUTPUT_LIMIT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lzss_pkg::rsp_type rsp_data
);

   localparam int AW  = $clog2(WINDOW_DEPTH);
   localparam int OCW = $clog2(OUTPUT_LIMIT + 1);

   // Sequencer: wait for a byte, walk its bits, run a match copy.
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PARSE = 3'b010,
      ST_COPY  = 3'b100
   } seq_state_type;

   seq_state_type     st_ff, st_in;
   logic [OCW-1:0]    outcnt_ff, outcnt_in;
   logic              pdone_ff, pdone_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lzss_pkg::rsp_type rsp_ff, rsp_in;

   lzss_pkg::parse_ctrl_type   pctl;
   lzss_pkg::parse_status_type pstat;
   lzss_pkg::win_ctrl_type     wctl;
   lzss_pkg::win_status_type   wstat;

   logic [7:0]             lit_byte;
   logic [AW-1:0]          match_idx;
   logic [LENGTH_BITS-1:0] match_len;
   logic [7:0]             copy_byte;

   logic       accept;
   logic       out_free;
   logic       emit_byte_go;
   logic       emit_end_go;
   logic [7:0] emit_value;
   logic       emit_last;

   lzss_bit_parser #(
      .INDEX_BITS   (INDEX_BITS),
      .LENGTH_BITS  (LENGTH_BITS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pctl),
      .in_byte   (req_data.in_byte),
      .status    (pstat),
      .lit_byte  (lit_byte),
      .match_idx (match_idx),
      .match_len (match_len)
   );

   lzss_window_copy #(
      .LENGTH_BITS  (LENGTH_BITS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (wctl),
      .lit_byte  (lit_byte),
      .copy_idx  (match_idx),
      .copy_len  (match_len),
      .status    (wstat),
      .copy_byte (copy_byte)
   );

   always_comb begin
      // The output slot is free when empty or being drained this cycle.
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (st_ff != ST_IDLE) || wstat.clearing;
      accept    = req_valid && !req_stall;

      st_in     = st_ff;
      pdone_in  = pdone_ff;
      outcnt_in = outcnt_ff;
      pctl      = '0;
      wctl      = '0;

      emit_byte_go = 1'b0;
      emit_end_go  = 1'b0;
      emit_value   = 8'd0;
      emit_last    = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.start_packet) begin
                  pdone_in        = 1'b0;
                  outcnt_in       = '0;
                  wctl.set_origin = 1'b1;
               end
               // drop bytes that trail an end token until the next packet start
               if (req_data.start_packet || !pdone_ff) begin
                  pctl.load    = 1'b1;
                  pctl.restart = req_data.start_packet;
                  st_in        = ST_PARSE;
               end
            end
         end
         ST_PARSE: begin
            if (!pstat.busy) begin
               st_in = ST_IDLE;
            end else if (pstat.ev_literal) begin
               // hold the bit until the literal has somewhere to go
               if (out_free) begin
                  pctl.advance = 1'b1;
                  wctl.lit_wr  = 1'b1;
                  emit_byte_go = 1'b1;
                  emit_value   = lit_byte;
                  emit_last    = 1'b1;
                  if (pstat.last_bit) st_in = ST_IDLE;
               end
            end else if (pstat.ev_end) begin
               if (out_free) begin
                  pctl.advance = 1'b1;
                  emit_end_go  = 1'b1;
                  pdone_in     = 1'b1;
                  st_in        = ST_IDLE;
               end
            end else if (pstat.ev_match) begin
               pctl.advance    = 1'b1;
               wctl.copy_start = 1'b1;
               st_in           = ST_COPY;
            end else begin
               pctl.advance = 1'b1;
               if (pstat.last_bit) st_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (wstat.copy_ready && out_free) begin
               wctl.copy_take = 1'b1;
               emit_byte_go   = 1'b1;
               emit_value     = copy_byte;
               emit_last      = wstat.copy_last;
               // resume the remaining bits of the byte after the last copied byte
               if (wstat.copy_last) st_in = ST_PARSE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_byte_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in.last_of_run = emit_last;
         rsp_in.stream_end  = 1'b0;
         if (outcnt_ff < OCW'(OUTPUT_LIMIT)) begin
            outcnt_in         = outcnt_ff + OCW'(1);
            rsp_in.out_byte   = emit_value;
            rsp_in.data_valid = 1'b1;
            rsp_in.overflow   = 1'b0;
         end else begin
            // past the packet limit: the byte still went into the window
            rsp_in.out_byte   = 8'd0;
            rsp_in.data_valid = 1'b0;
            rsp_in.overflow   = 1'b1;
         end
      end else if (emit_end_go) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = 8'd0;
         rsp_in.data_valid  = 1'b0;
         rsp_in.last_of_run = 1'b1;
         rsp_in.stream_end  = 1'b1;
         rsp_in.overflow    = 1'b0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         outcnt_ff    <= '0;
         pdone_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         outcnt_ff    <= outcnt_in;
         pdone_ff     <= pdone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/lzss_bit_parser.sv
// Bit-serial token parser: shifts one compressed bit per cycle while advanced, MSB first.
// Depends on lzss_pkg for control and status structs and constants.
module lzss_bit_parser #(
   parameter int INDEX_BITS   = 12,
   parameter int LENGTH_BITS  = 4,
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lzss_pkg::parse_ctrl_type        ctrl,
   input  logic [7:0]                      in_byte,
   output lzss_pkg::parse_status_type      status,
   output logic [7:0]                      lit_byte,
   output logic [$clog2(WINDOW_DEPTH)-1:0] match_idx,
   output logic [LENGTH_BITS-1:0]          match_len
);

   localparam int ACC_W = (INDEX_BITS > lzss_pkg::BYTE_BITS) ? INDEX_BITS : lzss_pkg::BYTE_BITS;
   localparam int CNT_W = $clog2(ACC_W);
   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam logic [AW:0] DEPTH_W = (AW+1)'(WINDOW_DEPTH);

   typedef enum logic [3:0] {
      PH_FLAG    = 4'b0001,
      PH_LITERAL = 4'b0010,
      PH_INDEX   = 4'b0100,
      PH_LENGTH  = 4'b1000
   } phase_type;

   phase_type              ph_ff, ph_in;
   logic [7:0]             sh_ff, sh_in;
   logic [3:0]             left_ff, left_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [AW-1:0]          mod_ff, mod_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic             bit_w;
   logic [ACC_W-1:0] acc_shift;
   logic [AW:0]      mod_sum;
   logic [AW:0]      mod_red;
   logic             lit_done;
   logic             idx_done;
   logic             is_end;
   logic             len_done;

   always_comb begin
      bit_w     = sh_ff[7];
      acc_shift = {acc_ff[ACC_W-2:0], bit_w};
      // index mod window depth, one bit at a time: stays below twice the depth
      mod_sum   = {mod_ff, bit_w};
      mod_red   = (mod_sum >= DEPTH_W) ? (mod_sum - DEPTH_W) : mod_sum;

      lit_done  = (ph_ff == PH_LITERAL) && (cnt_ff == CNT_W'(lzss_pkg::BYTE_BITS - 1));
      idx_done  = (ph_ff == PH_INDEX) && (cnt_ff == CNT_W'(INDEX_BITS - 1));
      is_end    = (acc_shift[INDEX_BITS-1:0] == INDEX_BITS'(lzss_pkg::END_CODE));
      len_done  = (ph_ff == PH_LENGTH) && (cnt_ff == CNT_W'(LENGTH_BITS - 1));

      status.busy       = (left_ff != 4'd0);
      status.last_bit   = (left_ff == 4'd1);
      status.ev_literal = lit_done;
      status.ev_end     = idx_done && is_end;
      status.ev_match   = len_done;

      lit_byte  = acc_shift[7:0];
      match_idx = mod_ff;
      match_len = {len_ff[LENGTH_BITS-2:0], bit_w};

      ph_in   = ph_ff;
      sh_in   = sh_ff;
      left_in = left_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mod_in  = mod_ff;
      len_in  = len_ff;

      if (ctrl.load) begin
         sh_in   = in_byte;
         left_in = 4'(lzss_pkg::BYTE_BITS);
         if (ctrl.restart) begin
            ph_in  = PH_FLAG;
            cnt_in = '0;
         end
      end else if (ctrl.advance) begin
         sh_in   = {sh_ff[6:0], 1'b0};
         left_in = left_ff - 4'd1;
         unique case (ph_ff)
            PH_FLAG: begin
               cnt_in = '0;
               acc_in = '0;
               mod_in = '0;
               ph_in  = bit_w ? PH_LITERAL : PH_INDEX;
            end
            PH_LITERAL: begin
               acc_in = acc_shift;
               cnt_in = cnt_ff + CNT_W'(1);
               if (lit_done) ph_in = PH_FLAG;
            end
            PH_INDEX: begin
               acc_in = acc_shift;
               mod_in = mod_red[AW-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
               if (idx_done) begin
                  cnt_in = '0;
                  ph_in  = is_end ? PH_FLAG : PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               len_in = match_len;
               cnt_in = cnt_ff + CNT_W'(1);
               if (len_done) ph_in = PH_FLAG;
            end
            default: ph_in = PH_FLAG;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_FLAG;
         left_ff <= 4'd0;
         cnt_ff  <= '0;
      end else begin
         ph_ff   <= ph_in;
         left_ff <= left_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      mod_ff <= mod_in;
      len_ff <= len_in;
   end

endmodule

// File: src/lzss_window_copy.sv
// Circular history window with write pointer, clearing sweep and match copy engine.
// Depends on lzss_pkg for control and status structs.
module lzss_window_copy #(
   parameter int LENGTH_BITS  = 4,
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lzss_pkg::win_ctrl_type          ctrl,
   input  logic [7:0]                      lit_byte,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] copy_idx,
   input  logic [LENGTH_BITS-1:0]          copy_len,
   output lzss_pkg::win_status_type        status,
   output logic [7:0]                      copy_byte
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int LW = LENGTH_BITS + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   logic [7:0] mem [WINDOW_DEPTH];

   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic          cp_active_ff, cp_active_in;
   logic          cp_have_ff, cp_have_in;
   logic [AW-1:0] cp_addr_ff, cp_addr_in;
   logic [LW-1:0] cp_left_ff, cp_left_in;
   logic [7:0]    rd_data_ff;

   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   always_comb begin
      rd_en   = cp_active_ff && !cp_have_ff;
      wr_en   = clr_ff || ctrl.lit_wr || ctrl.copy_take;
      wr_addr = clr_ff ? clr_addr_ff : wpos_ff;
      wr_data = clr_ff ? 8'd0 : (ctrl.copy_take ? rd_data_ff : lit_byte);

      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = (clr_addr_ff == LAST_ADDR) ? '0 : clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) clr_in = 1'b0;
      end

      wpos_in = wpos_ff;
      if (ctrl.set_origin) begin
         wpos_in = AW'(1);
      end else if (ctrl.lit_wr || ctrl.copy_take) begin
         wpos_in = (wpos_ff == LAST_ADDR) ? '0 : wpos_ff + AW'(1);
      end

      cp_active_in = cp_active_ff;
      cp_have_in   = cp_have_ff;
      cp_addr_in   = cp_addr_ff;
      cp_left_in   = cp_left_ff;
      if (ctrl.copy_start) begin
         cp_active_in = 1'b1;
         cp_have_in   = 1'b0;
         cp_addr_in   = copy_idx;
         cp_left_in   = LW'(copy_len) + LW'(2);
      end else if (rd_en) begin
         cp_have_in = 1'b1;
      end else if (ctrl.copy_take) begin
         // next read is issued after this write lands, so overlapping runs see it
         cp_have_in = 1'b0;
         cp_addr_in = (cp_addr_ff == LAST_ADDR) ? '0 : cp_addr_ff + AW'(1);
         cp_left_in = cp_left_ff - LW'(1);
         if (cp_left_ff == LW'(1)) cp_active_in = 1'b0;
      end

      status.clearing   = clr_ff;
      status.copy_ready = cp_have_ff;
      status.copy_last  = (cp_left_ff == LW'(1));
      copy_byte         = rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[cp_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         wpos_ff      <= AW'(1);
         cp_active_ff <= 1'b0;
         cp_have_ff   <= 1'b0;
         cp_left_ff   <= '0;
      end else begin
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         wpos_ff      <= wpos_in;
         cp_active_ff <= cp_active_in;
         cp_have_ff   <= cp_have_in;
         cp_left_ff   <= cp_left_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= cp_addr_in;
   end

endmodule

// File: bench/testbench.sv
// Self-checking bench for lzss_bitstream_decompressor: drives compressed byte streams and
// compares every decoded result against a bit-serial LZSS decoder kept in a scoreboard class.
// Depends on lzss_pkg and the decompressor RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int INDEX_BITS       = 12;
   localparam int LENGTH_BITS      = 4;
   localparam int WINDOW_DEPTH     = 4096;
   localparam int OUTPUT_LIMIT     = 4096;
   localparam int POS_BITS         = $clog2(WINDOW_DEPTH);
   localparam int MAX_LEN_CODE     = (1 << LENGTH_BITS) - 1;
   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 10;
   localparam int RANDOM_ITEMS     = 385;
   localparam int DRAIN_CYCLES     = 100;
   localparam int CYCLE_LIMIT      = 1_000_000;

   typedef enum logic [3:0] {
      WAIT_FLAG   = 4'b0001,
      GET_LITERAL = 4'b0010,
      GET_INDEX   = 4'b0100,
      GET_LENGTH  = 4'b1000
   } token_phase_type;

   // Scoreboard: decodes each accepted byte bit by bit and queues the results it implies.
   class lzss_decode_scoreboard;
      logic [7:0]          window_mem [WINDOW_DEPTH];
      logic [POS_BITS-1:0] write_pos;
      logic [16:0]         field_bits;
      int unsigned         field_len;
      token_phase_type     phase;
      int unsigned         delivered;
      bit                  packet_ended;
      lzss_pkg::rsp_type   expected_q[$];
      int                  errors;
      int                  checked;
      int                  end_tokens;
      int                  dropped;

      function new();
         foreach (window_mem[i]) window_mem[i] = 8'h00;
         write_pos    = POS_BITS'(1);
         field_bits   = '0;
         field_len    = 0;
         phase        = WAIT_FLAG;
         delivered    = 0;
         packet_ended = 1'b0;
         errors       = 0;
         checked      = 0;
         end_tokens   = 0;
         dropped      = 0;
      endfunction

      function void store_byte(logic [7:0] value);
         lzss_pkg::rsp_type r;
         window_mem[write_pos] = value;
         write_pos = write_pos + 1'b1;
         r = '0;
         if (delivered < OUTPUT_LIMIT) begin
            delivered++;
            r.out_byte   = value;
            r.data_valid = 1'b1;
         end else begin
            r.overflow = 1'b1;
            dropped++;
         end
         expected_q.push_back(r);
      endfunction

      function void note_request(lzss_pkg::req_type req);
         int                  first;
         int                  k;
         int unsigned         i;
         int unsigned         copy_len;
         logic                bit_now;
         logic [POS_BITS-1:0] src;
         lzss_pkg::rsp_type   tail;
         first = expected_q.size();
         if (req.start_packet) begin
            field_bits   = '0;
            field_len    = 0;
            phase        = WAIT_FLAG;
            write_pos    = POS_BITS'(1);
            delivered    = 0;
            packet_ended = 1'b0;
         end
         if (packet_ended) return;
         for (k = 7; k >= 0 && !packet_ended; k--) begin
            bit_now = req.in_byte[k];
            unique case (phase)
               WAIT_FLAG: begin
                  field_bits = '0;
                  field_len  = 0;
                  phase      = bit_now ? GET_LITERAL : GET_INDEX;
               end
               GET_LITERAL: begin
                  field_bits = {field_bits[15:0], bit_now};
                  field_len++;
                  if (field_len >= 8) begin
                     store_byte(field_bits[7:0]);
                     phase = WAIT_FLAG;
                  end
               end
               GET_INDEX: begin
                  field_bits = {field_bits[15:0], bit_now};
                  field_len++;
                  if (field_len >= INDEX_BITS) begin
                     if (field_bits == lzss_pkg::END_CODE) begin
                        packet_ended = 1'b1;
                        phase        = WAIT_FLAG;
                        field_bits   = '0;
                        field_len    = 0;
                        tail         = '0;
                        tail.stream_end = 1'b1;
                        expected_q.push_back(tail);
                        end_tokens++;
                     end else begin
                        phase     = GET_LENGTH;
                        field_len = 0;
                     end
                  end
               end
               default: begin
                  field_bits = {field_bits[15:0], bit_now};
                  field_len++;
                  if (field_len >= LENGTH_BITS) begin
                     copy_len = field_bits[LENGTH_BITS-1:0] + 2;
                     src      = field_bits[LENGTH_BITS +: INDEX_BITS];
                     for (i = 0; i < copy_len; i++) begin
                        store_byte(window_mem[src]);
                        src = src + 1'b1;
                     end
                     phase      = WAIT_FLAG;
                     field_bits = '0;
                     field_len  = 0;
                  end
               end
            endcase
         end
         if (expected_q.size() > first) begin
            tail = expected_q.pop_back();
            tail.last_of_run = 1'b1;
            expected_q.push_back(tail);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("result %0d: %s mismatch: expected %0h, actual %0h",
                   checked, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(lzss_pkg::rsp_type got);
         lzss_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: out_byte %0h valid %0b last %0b end %0b ovf %0b",
                   got.out_byte, got.data_valid, got.last_of_run, got.stream_end, got.overflow);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("data_valid", 8'(want.data_valid), 8'(got.data_valid));
         compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
         compare_field("stream_end", 8'(want.stream_end), 8'(got.stream_end));
         compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
      endfunction
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   lzss_pkg::req_type req_data       = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   lzss_pkg::rsp_type rsp_data;

   lzss_decode_scoreboard sb;
   int    send_idle_pct  = 0;
   int    recv_stall_pct = 0;
   int    counted_items  = 0;
   int    items_sent     = 0;
   int    cycle_count    = 0;
   bit    stream_bits[$];

   lzss_bitstream_decompressor #(
      .INDEX_BITS  (INDEX_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .OUTPUT_LIMIT(OUTPUT_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Stall the result channel at random; the percentage follows the current idling phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Check every result transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp_data);
   end

   // Watchdog: end the run if the decompressor hangs or the stimulus never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Append a value to the bit stream, most significant bit first.
   function automatic void put_bits(int unsigned value, int width);
      int i;
      for (i = width - 1; i >= 0; i--) stream_bits.push_back(value[i]);
   endfunction

   function automatic void put_literal(logic [7:0] value);
      put_bits(1, 1);
      put_bits(32'(value), 8);
   endfunction

   function automatic void put_match(int unsigned index, int unsigned len_code);
      put_bits(0, 1);
      put_bits(index, INDEX_BITS);
      put_bits(len_code, LENGTH_BITS);
   endfunction

   function automatic void put_end();
      put_bits(0, 1);
      put_bits(lzss_pkg::END_CODE, INDEX_BITS);
   endfunction

   // Drive one input transaction starting at a falling edge; return at the falling edge after
   // acceptance. Idle cycles go before the item, never between valid and acceptance.
   task automatic send_request(logic [7:0] value, bit start);
      lzss_pkg::req_type req;
      req.in_byte      = value;
      req.start_packet = start;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      // Hold the payload until an edge sees valid without stall.
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(req);
      items_sent++;
      @(negedge clock);
   endtask

   // Pad the pending bits to a whole byte with random filler and send them as bytes.
   task automatic send_stream(bit start_first);
      int         i;
      int         n_bytes;
      logic [7:0] value;
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
      n_bytes = stream_bits.size() / 8;
      for (i = 0; i < n_bytes; i++) begin
         value = '0;
         repeat (8) value = {value[6:0], stream_bits.pop_front()};
         send_request(value, start_first && i == 0);
         counted_items++;
      end
   endtask

   // Build a packet of random tokens. Half the matches reach back into recent output so that
   // copies overlap the bytes being written; full_length forces every token to a longest match.
   task automatic random_packet(int n_tokens, bit closed, bit full_length);
      int          t;
      int unsigned produced;
      int unsigned len_code;
      int unsigned index;
      logic [7:0]  value;
      produced = 0;
      stream_bits.delete();
      for (t = 0; t < n_tokens; t++) begin
         if (!full_length && $urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 9))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = 8'($urandom_range(0, 255));
            endcase
            put_literal(value);
            produced++;
         end else begin
            len_code = full_length ? MAX_LEN_CODE : $urandom_range(0, MAX_LEN_CODE);
            if ($urandom_range(0, 1))
               index = (1 + produced + WINDOW_DEPTH - $urandom_range(1, 48)) % WINDOW_DEPTH;
            else
               index = $urandom_range(1, WINDOW_DEPTH - 1);
            // Never emit the end code by accident in the middle of a packet.
            if (index == lzss_pkg::END_CODE) index = WINDOW_DEPTH - 1;
            put_match(index, len_code);
            produced += len_code + 2;
         end
      end
      if (closed) put_end();
      send_stream(1'b1);
      // Trail up to two bytes after the end token; the decoder must ignore them.
      if (closed) repeat ($urandom_range(0, 2)) send_request(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      int p;
      int goal;
      int directed_items;
      int dice;
      int j;
      int send_mix [4];
      int recv_mix [4];
      send_mix = '{0, 56, 0, 36};
      recv_mix = '{0, 0, 56, 36};
      sb = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: literal extremes, shortest match, overlapping longest match, a read that
      // wraps past the top of the window, then the end token with ignored filler after it.
      put_literal(8'h00);
      put_literal(8'hFF);
      put_match(1, 0);
      put_match(4, MAX_LEN_CODE);
      put_match(WINDOW_DEPTH - 6, MAX_LEN_CODE);
      put_match(WINDOW_DEPTH - 1, 1);
      put_end();
      send_stream(1'b1);
      send_request(8'hFF, 1'b0);
      // Cut a packet off in the middle of an index; the next start flag must resync.
      put_literal(8'h5A);
      put_bits(0, 1);
      put_bits(0, 6);
      send_stream(1'b1);
      // First byte completes no token; the match wraps and reads entries no earlier packet wrote.
      put_match(WINDOW_DEPTH - 1, 0);
      put_literal(8'h81);
      put_end();
      send_stream(1'b1);
      directed_items = counted_items;

      // Random traffic over the four idling phases: mostly closed packets, some truncated
      // ones and bursts of raw noise with stray start flags.
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = send_mix[p];
         recv_stall_pct = recv_mix[p];
         goal = RANDOM_ITEMS * (p + 1) / 4;
         while (counted_items - directed_items < goal) begin
            dice = $urandom_range(0, 99);
            if (dice < 75) begin
               random_packet($urandom_range(1, 24), 1'b1, 1'b0);
            end else if (dice < 90) begin
               random_packet($urandom_range(1, 10), 1'b0, 1'b0);
            end else begin
               for (j = 0; j < $urandom_range(1, 6); j++) begin
                  send_request(8'($urandom_range(0, 255)),
                               j == 0 || $urandom_range(0, 3) == 0);
                  counted_items++;
               end
            end
         end
      end

      // Close with one packet of longest matches at full rate.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_packet(8, 1'b1, 1'b1);
      req_valid <= 1'b0;

      // Drain, then watch a while longer for stray results.
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_q.size());
         sb.errors++;
      end

      $display("summary: %0d input bytes, %0d results checked, %0d end tokens",
               items_sent, sb.checked, sb.end_tokens);
      $display("summary: %0d bytes dropped at the packet limit, %0d errors",
               sb.dropped, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
